>>> rtl/arpt_pkg.sv
`default_nettype none

package arpt_pkg;

  // pre-position countdown width in bits (16 to 40)
  localparam int CountdownBits = 24;

  localparam int AddrBits = 5;
  localparam int DataBits = 32;

  // register indexes (byte address is 4 * index)
  localparam logic [2:0] RegParkAz    = 3'd0;
  localparam logic [2:0] RegParkEl    = 3'd1;
  localparam logic [2:0] RegStopAz    = 3'd2;
  localparam logic [2:0] RegFullEl    = 3'd3;
  localparam logic [2:0] RegParkPass  = 3'd4;

  typedef enum logic [2:0] {
    OpSample = 3'd0,
    OpPoint  = 3'd1,
    OpTick   = 3'd2,
    OpStart  = 3'd3,
    OpStop   = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    KindPoint   = 2'd0,
    KindRequest = 2'd1,
    KindClose   = 2'd2
  } kind_e;

  typedef struct packed {
    logic [8:0] park_az;
    logic [7:0] park_el;
    logic [9:0] stop_az;
    logic       full_el;
    logic       park_pass;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [8:0]  azimuth;
    logic [7:0]  elevation;
    logic        is_last_point;
    logic [23:0] seconds_until_pass;
  } item_t;

  typedef struct packed {
    kind_e      kind;
    logic [8:0] az;
    logic [7:0] el;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } step_out_t;

endpackage

`default_nettype wire

>>> rtl/arpt_cfg.sv
`default_nettype none

module arpt_cfg (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [arpt_pkg::AddrBits-1:0] paddr,
  input  wire logic [arpt_pkg::DataBits-1:0] pwdata,
  output logic      [arpt_pkg::DataBits-1:0] prdata,
  output logic                              pready,
  output arpt_pkg::cfg_t                    cfg_o
);
  import arpt_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[4:2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        RegParkAz:   cfg_d.park_az   = pwdata[8:0];
        RegParkEl:   cfg_d.park_el   = pwdata[7:0];
        RegStopAz:   cfg_d.stop_az   = pwdata[9:0];
        RegFullEl:   cfg_d.full_el   = pwdata[0];
        RegParkPass: cfg_d.park_pass = pwdata[0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.park_az   <= '0;
      cfg_q.park_el   <= '0;
      cfg_q.stop_az   <= '1;
      cfg_q.full_el   <= 1'b0;
      cfg_q.park_pass <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // readback, stop azimuth sign extended
  always_comb begin
    case (idx)
      RegParkAz:   prdata = DataBits'(cfg_q.park_az);
      RegParkEl:   prdata = DataBits'(cfg_q.park_el);
      RegStopAz:   prdata = {{(DataBits-10){cfg_q.stop_az[9]}}, cfg_q.stop_az};
      RegFullEl:   prdata = DataBits'(cfg_q.full_el);
      RegParkPass: prdata = DataBits'(cfg_q.park_pass);
      default:     prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

>>> rtl/arpt_step.sv
`default_nettype none

module arpt_step (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             fire_i,
  input  wire arpt_pkg::item_t  item_i,
  input  wire arpt_pkg::cfg_t   cfg_i,
  output arpt_pkg::step_out_t   out_o
);
  import arpt_pkg::*;

  localparam logic signed [8:0] ElevReset = -9'sd181;
  localparam logic signed [8:0] ElevLos   = -9'sd3;
  localparam int CmpBits = (CountdownBits > 23) ? CountdownBits : 23;
  localparam logic [CmpBits-1:0] CountMax = CmpBits'({CountdownBits{1'b1}});

  logic                     running_q, running_d;
  logic                     following_q, following_d;
  logic                     flip_q, flip_d;
  logic signed [8:0]        prev_el_q, prev_el_d;
  logic [8:0]               prev_pt_q, prev_pt_d;
  logic                     await_q, await_d;
  logic [CountdownBits-1:0] count_q, count_d;
  logic                     cd_active_q, cd_active_d;

  logic signed [8:0]        elev;
  logic [7:0]               el_clamp;
  logic [8:0]               az_wrap;
  logic [9:0]               az_sum;
  logic [8:0]               az_flip;
  logic                     fol_now;
  logic                     los;
  logic [8:0]               pt_prev;
  logic [8:0]               stop_s;
  logic                     crosses;
  logic [CmpBits-1:0]       secs_ext;
  logic [CountdownBits-1:0] count_load;
  logic [CountdownBits-1:0] count_dec;
  res_t                     park_r, req_r, close_r, point_r;

  assign elev     = {item_i.elevation[7], item_i.elevation};
  assign el_clamp = item_i.elevation[7] ? 8'd0 : item_i.elevation;
  assign az_wrap  = (item_i.azimuth >= 9'd360) ? item_i.azimuth - 9'd360 : item_i.azimuth;
  assign az_sum   = {1'b0, item_i.azimuth} + 10'd180;
  assign az_flip  = (az_sum >= 10'd360) ? 9'(az_sum - 10'd360) : az_sum[8:0];
  assign fol_now  = following_q | ~item_i.elevation[7];
  assign los      = (prev_el_q >= ElevLos) && (elev <= ElevLos);

  // stop azimuth check between previous and current pass point
  assign pt_prev  = await_q ? item_i.azimuth : prev_pt_q;
  assign stop_s   = cfg_i.stop_az[8:0];
  assign crosses  = cfg_i.full_el & ~cfg_i.stop_az[9] &
                    (((pt_prev <= stop_s) && (stop_s <= item_i.azimuth)) ||
                     ((pt_prev >= stop_s) && (stop_s >= item_i.azimuth)));

  // seconds are positive here, saturate to the counter width
  assign secs_ext   = CmpBits'(item_i.seconds_until_pass[22:0]);
  assign count_load = (secs_ext > CountMax) ? CountdownBits'(CountMax)
                                            : CountdownBits'(secs_ext);
  assign count_dec  = (count_q != '0) ? count_q - CountdownBits'(1) : count_q;

  always_comb begin
    park_r  = '{kind: KindPoint, az: cfg_i.park_az, el: cfg_i.park_el, last: 1'b0};
    req_r   = '{kind: KindRequest, az: 9'd0, el: 8'd0, last: 1'b1};
    close_r = '{kind: KindClose, az: 9'd0, el: 8'd0, last: 1'b1};
    point_r = flip_q ? '{kind: KindPoint, az: az_flip, el: 8'd180 - el_clamp, last: 1'b1}
                     : '{kind: KindPoint, az: az_wrap, el: el_clamp, last: 1'b1};
  end

  always_comb begin
    running_d   = running_q;
    following_d = following_q;
    flip_d      = flip_q;
    prev_el_d   = prev_el_q;
    prev_pt_d   = prev_pt_q;
    await_d     = await_q;
    count_d     = count_q;
    cd_active_d = cd_active_q;
    out_o       = '{n: 2'd0, r0: req_r, r1: req_r};

    case (item_i.op)
      OpSample: begin
        if (running_q) begin
          following_d = fol_now;
          if (fol_now) begin
            if (los) begin
              following_d = 1'b0;
              cd_active_d = 1'b0;
              if (cfg_i.park_pass) begin
                out_o = '{n: 2'd2, r0: park_r, r1: req_r};
              end else begin
                out_o = '{n: 2'd1, r0: req_r, r1: req_r};
              end
            end else begin
              out_o = '{n: 2'd1, r0: point_r, r1: point_r};
            end
          end
          prev_el_d = elev;
        end
      end
      OpPoint: begin
        if (await_q) begin
          flip_d = 1'b0;
        end
        if (crosses) begin
          flip_d = 1'b1;
        end
        prev_pt_d = item_i.azimuth;
        await_d   = item_i.is_last_point;
        if (item_i.is_last_point) begin
          if ($signed(item_i.seconds_until_pass) < 24'sd180) begin
            following_d = 1'b1;
          end else begin
            count_d     = count_load;
            cd_active_d = 1'b1;
          end
        end
      end
      OpTick: begin
        if (cd_active_q) begin
          count_d = count_dec;
          if (count_dec == '0) begin
            following_d = 1'b1;
            cd_active_d = 1'b0;
          end
        end
      end
      OpStart: begin
        flip_d      = 1'b0;
        following_d = 1'b0;
        prev_el_d   = ElevReset;
        running_d   = 1'b1;
        if (cfg_i.park_pass) begin
          out_o = '{n: 2'd2, r0: park_r, r1: req_r};
        end else begin
          out_o = '{n: 2'd1, r0: req_r, r1: req_r};
        end
      end
      OpStop: begin
        running_d   = 1'b0;
        following_d = 1'b0;
        cd_active_d = 1'b0;
        if (cfg_i.park_pass) begin
          out_o = '{n: 2'd2, r0: park_r, r1: close_r};
        end else begin
          out_o = '{n: 2'd1, r0: close_r, r1: close_r};
        end
      end
      default: begin
        out_o = '{n: 2'd0, r0: req_r, r1: req_r};
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q   <= 1'b0;
      following_q <= 1'b0;
      flip_q      <= 1'b0;
      prev_el_q   <= ElevReset;
      prev_pt_q   <= '0;
      await_q     <= 1'b1;
      count_q     <= '0;
      cd_active_q <= 1'b0;
    end else if (fire_i) begin
      running_q   <= running_d;
      following_q <= following_d;
      flip_q      <= flip_d;
      prev_el_q   <= prev_el_d;
      prev_pt_q   <= prev_pt_d;
      await_q     <= await_d;
      count_q     <= count_d;
      cd_active_q <= cd_active_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/arpt_obuf.sv
`default_nettype none

module arpt_obuf (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                load_i,
  input  wire arpt_pkg::step_out_t step_i,
  output logic                     free_o,
  output logic                     valid_o,
  input  wire logic                ready_i,
  output arpt_pkg::res_t           res_o
);
  import arpt_pkg::*;

  res_t       slot0_q, slot1_q;
  logic [1:0] cnt_q;
  logic       take;

  assign valid_o = (cnt_q != 2'd0);
  assign take    = valid_o & ready_i;
  // room for a new pair once everything held is gone or the last one is being taken
  assign free_o  = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && take);
  assign res_o   = slot0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (load_i) begin
      cnt_q <= step_i.n;
    end else if (take) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      slot0_q <= step_i.r0;
      slot1_q <= step_i.r1;
    end else if (take) begin
      slot0_q <= slot1_q;
    end
  end

endmodule

`default_nettype wire

>>> rtl/antenna_rotator_pass_tracker.sv
`default_nettype none

// Antenna rotator pass tracker: turns tracking samples, next-pass azimuth points,
// one-second ticks and start/stop beats into rotator pointing commands, park
// commands, next-pass requests and a port-close beat. Each input beat is held in
// an input register and processed once the output pair register is empty or
// about to empty; its zero, one or two results are then shifted out one beat per
// cycle while m_axis_tready is high. Items with at most one result stream back
// to back; an item with two results (park plus request or close) holds the output
// until both are taken, so the next item waits. A beat passes through the input
// register and its results through the output pair register.
// Configuration goes through the APB port (byte address 4*i, 32-bit data) and must
// only be written while no beat is in flight.
module antenna_rotator_pass_tracker (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // input beats
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // [8:0] azimuth, [16:9] elevation, [40:17] seconds_until_pass
  input  wire logic [47:0]                   s_axis_tdata,
  // [2:0] op
  input  wire logic [2:0]                    s_axis_tuser,
  input  wire logic                          s_axis_tlast,
  // result beats
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // [8:0] command_azimuth, [16:9] command_elevation
  output logic [23:0]                        m_axis_tdata,
  // [1:0] kind
  output logic [1:0]                         m_axis_tuser,
  output logic                               m_axis_tlast,
  // configuration
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [arpt_pkg::AddrBits-1:0] paddr,
  input  wire logic [arpt_pkg::DataBits-1:0] pwdata,
  output logic      [arpt_pkg::DataBits-1:0] prdata,
  output logic                               pready
);
  import arpt_pkg::*;

  cfg_t      cfg;
  item_t     item_q;
  logic      in_valid_q;
  logic      obuf_free;
  logic      fire;
  logic      in_beat;
  step_out_t step_out;
  res_t      res;

  arpt_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // held beat is processed as soon as the output pair can take its results
  assign fire          = in_valid_q & obuf_free;
  assign s_axis_tready = ~in_valid_q | fire;
  assign in_beat       = s_axis_tvalid & s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_beat) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  // input payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      item_q.op                 <= s_axis_tuser;
      item_q.azimuth            <= s_axis_tdata[8:0];
      item_q.elevation          <= s_axis_tdata[16:9];
      item_q.seconds_until_pass <= s_axis_tdata[40:17];
      item_q.is_last_point      <= s_axis_tlast;
    end
  end

  arpt_step u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (item_q),
    .cfg_i  (cfg),
    .out_o  (step_out)
  );

  arpt_obuf u_obuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (fire),
    .step_i  (step_out),
    .free_o  (obuf_free),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (res)
  );

  assign m_axis_tdata = {7'd0, res.el, res.az};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

endmodule

`default_nettype wire
